[sv/assert_macros.svh]
// Assertion macros shared by the binner RTL.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSTFB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSTFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/nstfb_pkg.sv]
// Shared types and fixed constants of the nibble spectrum binner.
// Used by the lane, merge and top level files; depends on nothing.
package nstfb_pkg;

	localparam int CHANS_W    = 13;
	localparam int POLS_W     = 3;
	localparam int FBIN_W     = 7;
	localparam int TBIN_W     = 11;
	localparam int CNT_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int NIB_W      = 4;
	localparam int VAL_W      = 5;
	localparam int OUT_SUM_W  = 20;
	localparam int OUT_IDX_W  = 12;
	localparam int ROW_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FBIN_MAX   = 64;
	localparam int TBIN_MAX   = 1024;
	localparam int NUM_LANES  = 2;
	localparam int FIFO_DEPTH = 4;

	localparam logic [BYTE_W-1:0] HI_MASK   = 8'd240;
	localparam logic [BYTE_W-1:0] LO_MASK   = 8'd15;
	localparam int                NIB_SHIFT = 4;

	localparam logic [CHANS_W-1:0] CHANS_RST = 13'd1024;
	localparam logic [POLS_W-1:0]  POLS_RST  = 3'd1;
	localparam logic [FBIN_W-1:0]  FBIN_RST  = 7'd1;
	localparam logic [TBIN_W-1:0]  TBIN_RST  = 11'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANS = 3'd0,
		CFG_POLS  = 3'd1,
		CFG_FBIN  = 3'd2,
		CFG_TBIN  = 3'd3,
		CFG_START = 3'd4,
		CFG_COUNT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                 emit;
		logic                 last;
		logic [OUT_IDX_W-1:0] idx;
		logic [ROW_W-1:0]     row;
		logic [VAL_W-1:0]     val;
	} lane_tag_t;

	typedef struct packed {
		logic [OUT_SUM_W-1:0] sum;
		logic [OUT_IDX_W-1:0] idx;
		logic [ROW_W-1:0]     row;
		logic                 last;
	} lane_res_t;

endpackage

[sv/nstfb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module nstfb_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/nstfb_lane.sv]
// One accumulator lane: a RAM bank with a read-modify-write stage and write forwarding.
// Depends on nstfb_pkg and nstfb_ram.
module nstfb_lane #(
	parameter int SUM_WIDTH = 20,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_en,
	input  logic [AW-1:0]        req_addr,
	input  nstfb_pkg::lane_tag_t req_tag,
	input  logic                 clr_en,
	input  logic [AW-1:0]        clr_addr,
	output logic                 res_valid,
	output nstfb_pkg::lane_res_t res
);

	localparam int OSW = nstfb_pkg::OUT_SUM_W;
	localparam int SW1 = SUM_WIDTH + 1;

	logic                 en_s1;
	logic [AW-1:0]        addr_s1;
	nstfb_pkg::lane_tag_t tag_s1;

	logic                 fwd_vld_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [SUM_WIDTH-1:0] fwd_data_q;

	logic [SUM_WIDTH-1:0] rdata;
	logic [SUM_WIDTH-1:0] acc;
	logic [SW1-1:0]       sum_ext;
	logic [SUM_WIDTH-1:0] sat;
	logic                 wen;
	logic [AW-1:0]        waddr;
	logic [SUM_WIDTH-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1     <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			en_s1     <= req_en;
			fwd_vld_q <= wen;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= req_addr;
		tag_s1     <= req_tag;
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
	end

	nstfb_ram #(
		.WIDTH(SUM_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wen),
		.waddr(waddr),
		.wdata(wdata),
		.re   (req_en),
		.raddr(req_addr),
		.rdata(rdata)
	);

	// The RAM returns old data when the previous cycle wrote the same entry.
	assign acc     = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata;
	assign sum_ext = {1'b0, acc} + SW1'(tag_s1.val);
	assign sat     = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];

	assign wen   = clr_en || en_s1;
	assign waddr = clr_en ? clr_addr : addr_s1;
	assign wdata = (clr_en || tag_s1.emit) ? '0 : sat;

	assign res_valid = en_s1 && tag_s1.emit;
	assign res = '{sum: OSW'(sat), idx: tag_s1.idx, row: tag_s1.row, last: tag_s1.last};

endmodule

[sv/nstfb_merge.sv]
// Merging stage: queues the lane results of each byte and sends them out one per request.
// Depends on nstfb_pkg.
module nstfb_merge (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic [nstfb_pkg::NUM_LANES-1:0]                   res_vld,
	input  nstfb_pkg::lane_res_t [nstfb_pkg::NUM_LANES-1:0]   res,
	output logic                                              room,
	output logic                                              out_valid,
	input  logic                                              out_stall,
	output logic [nstfb_pkg::OUT_SUM_W-1:0]                   bin_sum,
	output logic [nstfb_pkg::OUT_IDX_W-1:0]                   chan_bin_index,
	output logic [nstfb_pkg::ROW_W-1:0]                       time_row_index,
	output logic                                              last_of_row
);

	localparam int DEPTH = nstfb_pkg::FIFO_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [nstfb_pkg::NUM_LANES-1:0]                 vld;
		nstfb_pkg::lane_res_t [nstfb_pkg::NUM_LANES-1:0] res;
	} pair_t;

	pair_t                fifo_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 sel_q;

	pair_t                head;
	nstfb_pkg::lane_res_t cur;
	logic                 push;
	logic                 take_hi;
	logic                 out_acc;
	logic                 pop;

	assign push    = |res_vld;
	assign head    = fifo_q[rd_ptr_q];
	assign take_hi = sel_q || !head.vld[0];
	assign cur     = take_hi ? head.res[1] : head.res[0];

	assign out_valid = (count_q != '0);
	assign out_acc   = out_valid && !out_stall;
	assign pop       = out_acc && (take_hi || !head.vld[1]);
	assign room      = (count_q <= CW'(DEPTH - 2));

	assign bin_sum        = cur.sum;
	assign chan_bin_index = cur.idx;
	assign time_row_index = cur.row;
	assign last_of_row    = cur.last;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {res_vld, res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sel_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (out_acc) begin
				sel_q <= !pop;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/nibble_spectrum_time_freq_binner_top.sv]
// Top level of the nibble spectrum time and frequency binner.
// Depends on nstfb_pkg, nstfb_lane, nstfb_merge and assert_macros.svh.
//
// Channel   Handshake             Payload
// in        in_valid / in_stall   sample_byte
// out       out_valid / out_stall bin_sum, chan_bin_index, time_row_index, last_of_row
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle unless stalled; its results are queued for output.
// The output sends one result per cycle unless stalled, so bytes with two results
// make the input wait for the output while whole time groups are being emitted.
// After reset and each write to a known config register a clearing pass zeroes the
// MAX_CHANNELS/2 entries (2048 by default) of both banks; input is stalled meanwhile.
// in_stall also rises when the result queue has no room for bytes in flight.
`include "assert_macros.svh"

module nibble_spectrum_time_freq_binner_top #(
	parameter int MAX_CHANNELS = 4096,
	parameter int MAX_POLS = 4,
	parameter int SUM_WIDTH = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [nstfb_pkg::BYTE_W-1:0]        sample_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nstfb_pkg::OUT_SUM_W-1:0]     bin_sum,
	output logic [nstfb_pkg::OUT_IDX_W-1:0]     chan_bin_index,
	output logic [nstfb_pkg::ROW_W-1:0]         time_row_index,
	output logic                                last_of_row,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nstfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nstfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CHANS_W = nstfb_pkg::CHANS_W;
	localparam int POLS_W  = nstfb_pkg::POLS_W;
	localparam int FBIN_W  = nstfb_pkg::FBIN_W;
	localparam int TBIN_W  = nstfb_pkg::TBIN_W;
	localparam int CNT_W   = nstfb_pkg::CNT_W;
	localparam int NIB_W   = nstfb_pkg::NIB_W;
	localparam int VAL_W   = nstfb_pkg::VAL_W;
	localparam int OIW     = nstfb_pkg::OUT_IDX_W;
	localparam int NL      = nstfb_pkg::NUM_LANES;

	localparam int CH_CAP     = (1 << CHANS_W) - 2;
	localparam int CH_EVEN    = MAX_CHANNELS - (MAX_CHANNELS % 2);
	localparam int EFF_MAX    = (CH_EVEN > CH_CAP) ? CH_CAP : CH_EVEN;
	localparam int USED_MAX   = EFF_MAX / 2;
	localparam int USED_W     = $clog2(USED_MAX + 1);
	localparam int ROW_MAX    = USED_MAX * MAX_POLS;
	localparam int RB_W       = $clog2(ROW_MAX + 1);
	localparam int ENTRY_W    = (EFF_MAX > 2) ? $clog2(EFF_MAX) : 1;
	localparam int BANK_DEPTH = USED_MAX;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int POL_W      = $clog2(MAX_POLS + 1);
	localparam int FH_MAX     = nstfb_pkg::FBIN_MAX / 2;
	localparam int FH_W       = $clog2(FH_MAX + 1);

	// Configuration registers.
	logic [CHANS_W-1:0] chans_q;
	logic [POLS_W-1:0]  pols_q;
	logic [FBIN_W-1:0]  fbin_q;
	logic [TBIN_W-1:0]  tbin_q;
	logic [CNT_W-1:0]   start_sample_q;
	logic [CNT_W-1:0]   sample_count_q;
	logic               cfg_known;
	logic               cfg_hit;

	// Effective settings.
	logic [CHANS_W-1:0] chans_even;
	logic [CHANS_W-1:0] eff_chans;
	logic [USED_W-1:0]  used_c;
	logic [POL_W-1:0]   pols_c;
	logic [RB_W-1:0]    row_c;
	logic [FH_W-1:0]    fbin_half_c;
	logic [TBIN_W-1:0]  tbin_eff_c;
	logic [USED_W-1:0]  used_q;
	logic [RB_W-1:0]    row_bytes_q;
	logic               fbin_one_q;
	logic [FH_W-1:0]    fbin_half_q;

	// Run state.
	logic [RB_W-1:0]    pos_q;
	logic [CNT_W-1:0]   spec_q;
	logic [CNT_W-1:0]   remain_q;
	logic [TBIN_W-1:0]  tgc_q;
	logic [FH_W-1:0]    fgc_q;
	logic [ENTRY_W-1:0] ptr_q;
	logic [CNT_W-1:0]   row_q;
	logic               clear_busy_q;
	logic [BANK_AW-1:0] clear_addr_q;

	// Per-byte decode.
	logic               in_acc;
	logic               fifo_room;
	logic [RB_W-1:0]    pos;
	logic               active;
	logic               group_end;
	logic               use_c;
	logic               row_end;
	logic               row_done;
	logic               close;
	logic [NIB_W-1:0]   hi_nib;
	logic [NIB_W-1:0]   lo_nib;
	logic [ENTRY_W-1:0] entry_c0;

	logic [NL-1:0]                       req_en;
	logic [BANK_AW-1:0]                  req_addr [NL];
	nstfb_pkg::lane_tag_t                req_tag [NL];
	logic [NL-1:0]                       lane_vld;
	nstfb_pkg::lane_res_t [NL-1:0]       lane_res;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_known = cfg_index inside {[nstfb_pkg::CFG_CHANS : nstfb_pkg::CFG_COUNT]};
	end

	assign cfg_hit = cfg_valid && cfg_ready && cfg_known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chans_q        <= nstfb_pkg::CHANS_RST;
			pols_q         <= nstfb_pkg::POLS_RST;
			fbin_q         <= nstfb_pkg::FBIN_RST;
			tbin_q         <= nstfb_pkg::TBIN_RST;
			start_sample_q <= '0;
			sample_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (nstfb_pkg::cfg_reg_t'(cfg_index))
				nstfb_pkg::CFG_CHANS: chans_q        <= cfg_data[CHANS_W-1:0];
				nstfb_pkg::CFG_POLS:  pols_q         <= cfg_data[POLS_W-1:0];
				nstfb_pkg::CFG_FBIN:  fbin_q         <= cfg_data[FBIN_W-1:0];
				nstfb_pkg::CFG_TBIN:  tbin_q         <= cfg_data[TBIN_W-1:0];
				nstfb_pkg::CFG_START: start_sample_q <= cfg_data[CNT_W-1:0];
				nstfb_pkg::CFG_COUNT: sample_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		chans_even = {chans_q[CHANS_W-1:1], 1'b0};
		if (chans_even < CHANS_W'(2)) begin
			eff_chans = CHANS_W'(2);
		end else if (chans_even > CHANS_W'(EFF_MAX)) begin
			eff_chans = CHANS_W'(EFF_MAX);
		end else begin
			eff_chans = chans_even;
		end
		used_c = USED_W'(eff_chans >> 1);

		if (pols_q == '0) begin
			pols_c = POL_W'(1);
		end else if (pols_q > POLS_W'(MAX_POLS)) begin
			pols_c = POL_W'(MAX_POLS);
		end else begin
			pols_c = POL_W'(pols_q);
		end
		row_c = RB_W'(RB_W'(used_c) * RB_W'(pols_c));

		if (fbin_q > FBIN_W'(nstfb_pkg::FBIN_MAX)) begin
			fbin_half_c = FH_W'(FH_MAX);
		end else begin
			fbin_half_c = FH_W'(fbin_q >> 1);
		end

		if (tbin_q == '0) begin
			tbin_eff_c = TBIN_W'(1);
		end else if (tbin_q > TBIN_W'(nstfb_pkg::TBIN_MAX)) begin
			tbin_eff_c = TBIN_W'(nstfb_pkg::TBIN_MAX);
		end else begin
			tbin_eff_c = tbin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			row_bytes_q <= '0;
			fbin_one_q  <= 1'b1;
			fbin_half_q <= '0;
		end else begin
			used_q      <= used_c;
			row_bytes_q <= row_c;
			fbin_one_q  <= (fbin_q <= FBIN_W'(1));
			fbin_half_q <= fbin_half_c;
		end
	end

	assign in_stall = clear_busy_q || !fifo_room;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		pos       = (pos_q >= row_bytes_q) ? '0 : pos_q;
		active    = (spec_q >= start_sample_q) && (remain_q != '0);
		group_end = (tgc_q == TBIN_W'(1));
		use_c     = active && (pos < RB_W'(used_q));
		row_end   = (pos == (RB_W'(used_q) - RB_W'(1)));
		row_done  = (({1'b0, pos} + 1'b1) >= {1'b0, row_bytes_q});
		close     = (fgc_q >= fbin_half_q) || row_end;
		hi_nib    = NIB_W'((sample_byte & nstfb_pkg::HI_MASK) >> nstfb_pkg::NIB_SHIFT);
		lo_nib    = NIB_W'(sample_byte & nstfb_pkg::LO_MASK);
		entry_c0  = ENTRY_W'({pos, 1'b0});
	end

	// Lane b owns the channels or bins whose index has parity b.
	always_comb begin
		req_en = '0;
		for (int b = 0; b < NL; b++) begin
			req_addr[b] = BANK_AW'(pos);
			req_tag[b]  = '0;
		end
		if (fbin_one_q) begin
			req_en = {NL{in_acc && use_c}};
			req_tag[0] = '{emit: group_end, last: 1'b0, idx: OIW'(entry_c0),
				row: row_q, val: VAL_W'(hi_nib)};
			req_tag[1] = '{emit: group_end, last: row_end, idx: OIW'(entry_c0 | ENTRY_W'(1)),
				row: row_q, val: VAL_W'(lo_nib)};
		end else begin
			req_en[ptr_q[0]] = in_acc && use_c;
			for (int b = 0; b < NL; b++) begin
				req_addr[b] = BANK_AW'(ptr_q >> 1);
				req_tag[b]  = '{emit: close && group_end, last: row_end, idx: OIW'(ptr_q),
					row: row_q, val: VAL_W'(hi_nib) + VAL_W'(lo_nib)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clear_addr_q <= '0;
		end else if (cfg_hit) begin
			clear_busy_q <= 1'b1;
			clear_addr_q <= '0;
		end else if (clear_busy_q) begin
			if (clear_addr_q == BANK_AW'(BANK_DEPTH - 1)) begin
				clear_busy_q <= 1'b0;
			end
			clear_addr_q <= clear_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			spec_q   <= '0;
			remain_q <= '0;
			tgc_q    <= TBIN_W'(1);
			fgc_q    <= FH_W'(1);
			ptr_q    <= '0;
			row_q    <= '0;
		end else if (clear_busy_q) begin
			pos_q    <= '0;
			spec_q   <= '0;
			remain_q <= sample_count_q;
			tgc_q    <= tbin_eff_c;
			fgc_q    <= FH_W'(1);
			ptr_q    <= '0;
			row_q    <= '0;
		end else if (in_acc) begin
			pos_q <= pos + 1'b1;
			if (use_c && !fbin_one_q) begin
				if (close) begin
					ptr_q <= ptr_q + 1'b1;
					fgc_q <= FH_W'(1);
				end else begin
					fgc_q <= fgc_q + 1'b1;
				end
			end
			if (row_done) begin
				if (active) begin
					remain_q <= remain_q - 1'b1;
					if (group_end) begin
						tgc_q <= tbin_eff_c;
						row_q <= row_q + 1'b1;
					end else begin
						tgc_q <= tgc_q - 1'b1;
					end
				end
				if (spec_q != '1) begin
					spec_q <= spec_q + 1'b1;
				end
				ptr_q <= '0;
				fgc_q <= FH_W'(1);
				pos_q <= '0;
			end
		end
	end

	for (genvar b = 0; b < NL; b++) begin : g_lane
		nstfb_lane #(
			.SUM_WIDTH(SUM_WIDTH),
			.DEPTH(BANK_DEPTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.req_en   (req_en[b]),
			.req_addr (req_addr[b]),
			.req_tag  (req_tag[b]),
			.clr_en   (clear_busy_q),
			.clr_addr (clear_addr_q),
			.res_valid(lane_vld[b]),
			.res      (lane_res[b])
		);
	end

	nstfb_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_vld       (lane_vld),
		.res           (lane_res),
		.room          (fifo_room),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bin_sum       (bin_sum),
		.chan_bin_index(chan_bin_index),
		.time_row_index(time_row_index),
		.last_of_row   (last_of_row)
	);

	`NSTFB_ASSERT_NEXT(a_cfg_starts_clear, clk, arst_n, cfg_hit, in_stall && clear_busy_q, "input not held off after a configuration write")
	`NSTFB_ASSERT_IMPLIES(a_binned_one_lane, clk, arst_n, !fbin_one_q, !(&lane_vld), "two lane results for one frequency bin")
	`NSTFB_ASSERT_IMPLIES(a_pair_together, clk, arst_n, fbin_one_q && (|lane_vld), &lane_vld, "channel pair emitted by one lane only")

endmodule

[dv/nibble_spectrum_time_freq_binner_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for the nibble spectrum time and frequency binner: a directed table, then corner
// and random settings with byte streams, checked by the table or a bit-accurate predictor.
// Depends on nstfb_pkg and the binner RTL only.

module nibble_spectrum_time_freq_binner_top_tb;

	localparam int CHANS_W    = nstfb_pkg::CHANS_W;
	localparam int POLS_W     = nstfb_pkg::POLS_W;
	localparam int FBIN_W     = nstfb_pkg::FBIN_W;
	localparam int TBIN_W     = nstfb_pkg::TBIN_W;
	localparam int BYTE_W     = nstfb_pkg::BYTE_W;
	localparam int OUT_SUM_W  = nstfb_pkg::OUT_SUM_W;
	localparam int OUT_IDX_W  = nstfb_pkg::OUT_IDX_W;
	localparam int ROW_W      = nstfb_pkg::ROW_W;
	localparam int CFG_IDX_W  = nstfb_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = nstfb_pkg::CFG_DATA_W;

	localparam int unsigned NUM_CHANS = 4096;
	localparam int unsigned NUM_POLS = 4;
	localparam int unsigned SUM_MAX = 32'h000F_FFFF;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int ITEM_TARGET = 1900;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic [31:0] chans;
		logic [31:0] pols;
		logic [31:0] fbin;
		logic [31:0] tbin;
		logic [31:0] start;
		logic [31:0] count;
	} setting_t;

	typedef struct {
		int                   setting;
		logic [7:0]           data;
		bit                   typed;
		int                   n;
		nstfb_pkg::lane_res_t r0;
		nstfb_pkg::lane_res_t r1;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     sample_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [OUT_SUM_W-1:0]  bin_sum;
	logic [OUT_IDX_W-1:0]  chan_bin_index;
	logic [ROW_W-1:0]      time_row_index;
	logic                  last_of_row;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	nibble_spectrum_time_freq_binner_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_byte(sample_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bin_sum(bin_sum),
		.chan_bin_index(chan_bin_index),
		.time_row_index(time_row_index),
		.last_of_row(last_of_row),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register copies and run state of the predictor.
	logic [CHANS_W-1:0] reg_chans;
	logic [POLS_W-1:0]  reg_pols;
	logic [FBIN_W-1:0]  reg_fbin;
	logic [TBIN_W-1:0]  reg_tbin;
	logic [31:0]        reg_start;
	logic [31:0]        reg_count;

	int unsigned          acc_store [0:NUM_CHANS-1];
	int unsigned          byte_pos;
	int unsigned          spec_seen;
	int unsigned          spec_left;
	int unsigned          tgrp_left;
	int unsigned          fgrp_fill;
	int unsigned          bin_ptr;
	int unsigned          row_num;
	nstfb_pkg::lane_res_t step_res [0:1];
	nstfb_pkg::lane_res_t bins_due [$];

	int fail_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int stall_pct = 20;
	int stall_hold = 0;

	setting_t dir_cfg [0:1] = '{
		'{32'd4, 32'd2, 32'd1, 32'd1, 32'd1, 32'd2},
		'{32'd6, 32'd1, 32'd4, 32'd2, 32'd0, 32'd3}
	};

	dir_row_t dir_rows [0:23] = '{
		'{0, 8'hFF, 1'b1, 0, '0, '0},
		'{0, 8'h00, 1'b1, 0, '0, '0},
		'{0, 8'hA5, 1'b1, 0, '0, '0},
		'{0, 8'h5A, 1'b1, 0, '0, '0},
		'{0, 8'hF0, 1'b1, 2, '{20'd15, 12'd0, 32'd0, 1'b0}, '{20'd0, 12'd1, 32'd0, 1'b0}},
		'{0, 8'h0F, 1'b1, 2, '{20'd0, 12'd2, 32'd0, 1'b0}, '{20'd15, 12'd3, 32'd0, 1'b1}},
		'{0, 8'hFF, 1'b1, 0, '0, '0},
		'{0, 8'hFF, 1'b1, 0, '0, '0},
		'{0, 8'hFF, 1'b1, 2, '{20'd15, 12'd0, 32'd1, 1'b0}, '{20'd15, 12'd1, 32'd1, 1'b0}},
		'{0, 8'h00, 1'b1, 2, '{20'd0, 12'd2, 32'd1, 1'b0}, '{20'd0, 12'd3, 32'd1, 1'b1}},
		'{0, 8'h12, 1'b1, 0, '0, '0},
		'{0, 8'h34, 1'b1, 0, '0, '0},
		'{0, 8'hFF, 1'b1, 0, '0, '0},
		'{0, 8'hEE, 1'b1, 0, '0, '0},
		'{1, 8'h11, 1'b0, 0, '0, '0},
		'{1, 8'h22, 1'b0, 0, '0, '0},
		'{1, 8'h33, 1'b0, 0, '0, '0},
		'{1, 8'hFF, 1'b0, 0, '0, '0},
		'{1, 8'hFF, 1'b0, 0, '0, '0},
		'{1, 8'hFF, 1'b0, 0, '0, '0},
		'{1, 8'h80, 1'b0, 0, '0, '0},
		'{1, 8'h08, 1'b0, 0, '0, '0},
		'{1, 8'h01, 1'b0, 0, '0, '0},
		'{1, 8'h10, 1'b0, 0, '0, '0}
	};

	setting_t corner_cfg [0:3] = '{
		'{32'd8191, 32'd7, 32'd127, 32'd0, 32'd0, 32'hFFFF_FFFF},
		'{32'd0, 32'd0, 32'd0, 32'd2047, 32'd0, 32'hFFFF_FFFF},
		'{32'd10, 32'd1, 32'd3, 32'd3, 32'd2, 32'd7},
		'{32'd16, 32'd2, 32'd8, 32'd1, 32'hFFFF_FFFF, 32'd5}
	};
	int corner_len [0:3] = '{300, 40, 80, 40};

	function automatic int unsigned eff_chans();
		int unsigned c;
		c = reg_chans;
		c[0] = 1'b0;
		if (c < 2) c = 2;
		if (c > NUM_CHANS) c = NUM_CHANS;
		return c;
	endfunction

	function automatic int unsigned eff_pols();
		if (reg_pols == 0) return 1;
		if (reg_pols > NUM_POLS) return NUM_POLS;
		return reg_pols;
	endfunction

	function automatic int unsigned eff_fbin();
		if (reg_fbin == 0) return 1;
		if (reg_fbin > nstfb_pkg::FBIN_MAX) return nstfb_pkg::FBIN_MAX;
		return reg_fbin;
	endfunction

	function automatic int unsigned eff_tbin();
		if (reg_tbin == 0) return 1;
		if (reg_tbin > nstfb_pkg::TBIN_MAX) return nstfb_pkg::TBIN_MAX;
		return reg_tbin;
	endfunction

	task automatic restart_run();
		foreach (acc_store[i]) acc_store[i] = 0;
		byte_pos = 0;
		spec_seen = 0;
		spec_left = reg_count;
		tgrp_left = eff_tbin();
		fgrp_fill = 1;
		bin_ptr = 0;
		row_num = 0;
	endtask

	task automatic model_reset();
		reg_chans = nstfb_pkg::CHANS_RST;
		reg_pols = nstfb_pkg::POLS_RST;
		reg_fbin = nstfb_pkg::FBIN_RST;
		reg_tbin = nstfb_pkg::TBIN_RST;
		reg_start = '0;
		reg_count = '0;
		restart_run();
	endtask

	task automatic model_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		case (idx)
			nstfb_pkg::CFG_CHANS: reg_chans = d[CHANS_W-1:0];
			nstfb_pkg::CFG_POLS:  reg_pols = d[POLS_W-1:0];
			nstfb_pkg::CFG_FBIN:  reg_fbin = d[FBIN_W-1:0];
			nstfb_pkg::CFG_TBIN:  reg_tbin = d[TBIN_W-1:0];
			nstfb_pkg::CFG_START: reg_start = d;
			nstfb_pkg::CFG_COUNT: reg_count = d;
			default: return;
		endcase
		restart_run();
	endtask

	function automatic void accumulate(input int unsigned idx, input int unsigned v);
		int unsigned s;
		s = acc_store[idx] + v;
		if (s > SUM_MAX) s = SUM_MAX;
		acc_store[idx] = s;
	endfunction

	function automatic void post_bin(input int unsigned idx, input bit last, inout int n);
		step_res[n].sum = OUT_SUM_W'(acc_store[idx]);
		step_res[n].idx = OUT_IDX_W'(idx);
		step_res[n].row = row_num;
		step_res[n].last = last;
		acc_store[idx] = 0;
		n++;
	endfunction

	task automatic predict_byte(input logic [BYTE_W-1:0] b, output int n);
		int unsigned used;
		int unsigned row_bytes;
		int unsigned fb;
		int unsigned hi;
		int unsigned lo;
		int unsigned c;
		int unsigned p;
		bit active;
		bit group_end;
		bit row_end;
		n = 0;
		used = eff_chans() / 2;
		row_bytes = used * eff_pols();
		fb = eff_fbin();
		hi = (b & nstfb_pkg::HI_MASK) >> nstfb_pkg::NIB_SHIFT;
		lo = b & nstfb_pkg::LO_MASK;
		active = spec_seen >= reg_start && spec_left != 0;
		group_end = tgrp_left == 1;
		if (byte_pos >= row_bytes) byte_pos = 0;
		if (active && byte_pos < used) begin
			row_end = byte_pos == used - 1;
			if (fb == 1) begin
				c = byte_pos * 2;
				accumulate(c, hi);
				accumulate(c + 1, lo);
				if (group_end) begin
					post_bin(c, 1'b0, n);
					post_bin(c + 1, row_end, n);
				end
			end else begin
				p = bin_ptr;
				accumulate(p, hi + lo);
				if (fgrp_fill >= fb / 2 || row_end) begin
					if (group_end) post_bin(p, row_end, n);
					bin_ptr = (p + 1) & 32'hFFF;
					fgrp_fill = 1;
				end else begin
					fgrp_fill++;
				end
			end
		end
		if (byte_pos + 1 >= row_bytes) begin
			if (active) begin
				spec_left--;
				if (group_end) begin
					tgrp_left = eff_tbin();
					row_num++;
				end else begin
					tgrp_left--;
				end
			end
			if (spec_seen != 32'hFFFF_FFFF) spec_seen++;
			bin_ptr = 0;
			fgrp_fill = 1;
			byte_pos = 0;
		end else begin
			byte_pos++;
		end
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (bins_due.size() != 0) @(posedge clk);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input int gap, input bit use_model);
		int n;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		predict_byte(b, n);
		if (use_model) begin
			for (int i = 0; i < n; i++) bins_due.push_back(step_res[i]);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model_write(idx, d);
	endtask

	function automatic logic [31:0] junk_above(input logic [31:0] v, input int w, input bit on);
		logic [31:0] j;
		if (!on) return v;
		j = $urandom;
		return v | (j << w);
	endfunction

	// Writes go in only once the block is idle: nothing expected and the pipeline settled.
	task automatic apply_setting(input setting_t s, input bit noisy);
		hold_input();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(nstfb_pkg::CFG_CHANS,
			junk_above(s.chans, CHANS_W, noisy && $urandom_range(0, 2) == 0));
		write_reg(nstfb_pkg::CFG_POLS,
			junk_above(s.pols, POLS_W, noisy && $urandom_range(0, 2) == 0));
		write_reg(nstfb_pkg::CFG_FBIN,
			junk_above(s.fbin, FBIN_W, noisy && $urandom_range(0, 2) == 0));
		write_reg(nstfb_pkg::CFG_TBIN,
			junk_above(s.tbin, TBIN_W, noisy && $urandom_range(0, 2) == 0));
		write_reg(nstfb_pkg::CFG_START, s.start);
		write_reg(nstfb_pkg::CFG_COUNT, s.count);
		if (noisy && $urandom_range(0, 3) == 0) begin
			write_reg(CFG_SPARE_LO, $urandom);
			write_reg(CFG_SPARE_HI, $urandom);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic setting_t rand_setting();
		setting_t s;
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) s.chans = 2 * $urandom_range(1, 16);
		else if (r < 92) s.chans = $urandom_range(0, 40);
		else s.chans = $urandom_range(0, 8191);
		s.pols = $urandom_range(0, 1) ? 32'd1 : 32'($urandom_range(0, 7));
		case ($urandom_range(0, 9))
			0: s.fbin = 0;
			1, 2: s.fbin = 1;
			3: s.fbin = 2;
			4: s.fbin = 4;
			5: s.fbin = 3;
			6: s.fbin = 64;
			7: s.fbin = 127;
			8: s.fbin = 2 * $urandom_range(1, 8);
			default: s.fbin = $urandom_range(0, 127);
		endcase
		r = $urandom_range(0, 99);
		if (r < 50) s.tbin = $urandom_range(1, 3);
		else if (r < 85) s.tbin = $urandom_range(0, 6);
		else s.tbin = $urandom_range(0, 2047);
		r = $urandom_range(0, 99);
		if (r < 60) s.start = 0;
		else if (r < 90) s.start = $urandom_range(0, 3);
		else s.start = $urandom;
		r = $urandom_range(0, 99);
		if (r < 20) s.count = 32'hFFFF_FFFF;
		else if (r < 90) s.count = $urandom_range(1, 30);
		else if (r < 95) s.count = 0;
		else s.count = $urandom;
		return s;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'h00;
		if (r < 20) return 8'hFF;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic int pick_gap(input bit burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_bins
		nstfb_pkg::lane_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bins_due.size() == 0) begin
				$error("unexpected result: bin_sum %0d, chan_bin_index %0d, time_row_index %0d",
					bin_sum, chan_bin_index, time_row_index);
				fail_count++;
			end else begin
				want = bins_due.pop_front();
				if (bin_sum !== want.sum) begin
					$error("bin_sum: expected %0d, got %0d", want.sum, bin_sum);
					fail_count++;
				end
				if (chan_bin_index !== want.idx) begin
					$error("chan_bin_index: expected %0d, got %0d", want.idx, chan_bin_index);
					fail_count++;
				end
				if (time_row_index !== want.row) begin
					$error("time_row_index: expected %0d, got %0d", want.row, time_row_index);
					fail_count++;
				end
				if (last_of_row !== want.last) begin
					$error("last_of_row: expected %0d, got %0d", want.last, last_of_row);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nibble_spectrum_time_freq_binner_top_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int cur;
		int phase;
		int n_items;
		bit burst;
		model_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cur = -1;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].setting != cur) begin
				cur = dir_rows[i].setting;
				apply_setting(dir_cfg[cur], 1'b0);
			end
			send_byte(dir_rows[i].data, pick_gap(1'b0), !dir_rows[i].typed);
			if (dir_rows[i].typed && dir_rows[i].n > 0) bins_due.push_back(dir_rows[i].r0);
			if (dir_rows[i].typed && dir_rows[i].n > 1) bins_due.push_back(dir_rows[i].r1);
		end

		foreach (corner_cfg[i]) begin
			apply_setting(corner_cfg[i], 1'b0);
			repeat (corner_len[i]) send_byte(pick_byte(), pick_gap(1'b0), 1'b1);
		end

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			apply_setting(rand_setting(), 1'b1);
			burst = $urandom_range(0, 3) == 0;
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 10;
				2: stall_pct = 30;
				default: stall_pct = 60;
			endcase
			n_items = $urandom_range(60, 200);
			for (int i = 0; i < n_items; i++) begin
				if (phase % 4 == 1 && i == n_items / 2) begin
					hold_input();
					wait_drained();
				end
				send_byte(pick_byte(), pick_gap(burst), 1'b1);
			end
			phase++;
		end

		hold_input();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("nibble_spectrum_time_freq_binner_top_tb: done, clean");
		end else begin
			$display("nibble_spectrum_time_freq_binner_top_tb: done, errors");
		end
		$finish;
	end

endmodule
